// ----- src/cct_pkg.sv -----
package cct_pkg;

   // Lexer modes, one-hot
   typedef enum logic [4:0] {
      MODE_IDLE = 5'b00001,
      MODE_WORD = 5'b00010,
      MODE_STR  = 5'b00100,
      MODE_ESC  = 5'b01000,
      MODE_HALT = 5'b10000
   } mode_type;

   // Result event codes
   localparam logic [1:0] EV_BYTE  = 2'd0;
   localparam logic [1:0] EV_DONE  = 2'd1;
   localparam logic [1:0] EV_ERROR = 2'd2;
   localparam logic [1:0] EV_END   = 2'd3;

   // Error codes
   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_UNTERM = 2'd1;
   localparam logic [1:0] ERR_ZERO   = 2'd2;
   localparam logic [1:0] ERR_UNEXP  = 2'd3;

   // Special bytes
   localparam logic [7:0] SEP_MAX      = 8'd32;
   localparam logic [7:0] QUOTE_SINGLE = 8'h27;
   localparam logic [7:0] QUOTE_DOUBLE = 8'h22;
   localparam logic [7:0] ESCAPE_BYTE  = 8'h5C;
   localparam logic [7:0] ZERO_BYTE    = 8'h00;

   // Class registers: four operator words, then four word-character words
   localparam int          CFG_REGS     = 8;
   localparam int          CFG_IDX_W    = 3;
   localparam int          CFG_ADDR_W   = 6;
   localparam int          CFG_DATA_W   = 64;
   localparam logic [63:0] CFG_RESET [CFG_REGS] = '{
      64'd0, 64'd0, 64'd0, 64'd0,
      64'd287948901175001088, 64'd576460745995190270, 64'd0, 64'd0
   };

   typedef struct packed {
      logic [255:0] op;
      logic [255:0] word;
   } class_maps_type;

   typedef struct packed {
      logic [1:0] event_res;
      logic [7:0] token_byte;
      logic [7:0] token_kind;
      logic [1:0] error_code;
      logic       last_result;
   } res_type;

   // Up to two results for one input beat, r0 first
   typedef struct packed {
      logic [1:0] count;
      res_type    r0;
      res_type    r1;
   } step_type;

   function automatic res_type mk_res(logic [1:0] ev, logic [7:0] tb,
                                      logic [7:0] tk, logic [1:0] err);
      res_type r;
      r.event_res   = ev;
      r.token_byte  = tb;
      r.token_kind  = tk;
      r.error_code  = err;
      r.last_result = 1'b0;
      return r;
   endfunction

endpackage

// ----- src/cct_req_if.sv -----
interface cct_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_marker;

   modport source (output valid, output data_byte, output end_marker, input ready);
   modport sink   (input valid, input data_byte, input end_marker, output ready);
endinterface

// ----- src/cct_rsp_if.sv -----
interface cct_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] event_res;
   logic [7:0] token_byte;
   logic [7:0] token_kind;
   logic [1:0] error_code;
   logic       last_result;

   modport source (output valid, output event_res, output token_byte, output token_kind,
                   output error_code, output last_result, input ready);
   modport sink   (input valid, input event_res, input token_byte, input token_kind,
                   input error_code, input last_result, output ready);
endinterface

// ----- src/cct_csr.sv -----
module cct_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [cct_pkg::CFG_ADDR_W-1:0]    csr_paddr,
   input  logic [cct_pkg::CFG_DATA_W-1:0]    csr_pwdata,
   output logic [cct_pkg::CFG_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready,
   output cct_pkg::class_maps_type           maps
);

   logic [cct_pkg::CFG_DATA_W-1:0] cls_ff [cct_pkg::CFG_REGS];
   logic [cct_pkg::CFG_IDX_W-1:0]  idx;
   logic                           wr_en;

   assign idx        = csr_paddr[cct_pkg::CFG_ADDR_W-1:3];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;
   assign csr_prdata = cls_ff[idx];

   // Write a class register in the access phase
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < cct_pkg::CFG_REGS; i++) begin
            cls_ff[i] <= cct_pkg::CFG_RESET[i];
         end
      end else if (wr_en) begin
         cls_ff[idx] <= csr_pwdata;
      end
   end

   // Lay out the two 256-bit class maps, bit n is byte n
   assign maps.op   = {cls_ff[3], cls_ff[2], cls_ff[1], cls_ff[0]};
   assign maps.word = {cls_ff[7], cls_ff[6], cls_ff[5], cls_ff[4]};

endmodule

// ----- src/cct_lexer.sv -----
module cct_lexer (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic [7:0]              data_byte,
   input  logic                    end_marker,
   input  cct_pkg::class_maps_type maps,
   output cct_pkg::step_type       step
);

   cct_pkg::mode_type mode_ff, mode_in;
   logic [7:0]        kind_ff, kind_in;

   logic              op_hit, word_hit;
   cct_pkg::mode_type s_mode;
   logic [7:0]        s_kind;
   logic              s_has;
   cct_pkg::res_type  s_res;
   cct_pkg::res_type  r0, r1;
   logic [1:0]        n;

   // Class lookup; separators never match
   assign op_hit   = (data_byte > cct_pkg::SEP_MAX) & maps.op[data_byte];
   assign word_hit = (data_byte > cct_pkg::SEP_MAX) & maps.word[data_byte];

   // Start of a token from idle
   always_comb begin
      s_mode = cct_pkg::MODE_IDLE;
      s_kind = kind_ff;
      s_has  = 1'b0;
      s_res  = cct_pkg::mk_res(cct_pkg::EV_BYTE, 8'd0, 8'd0, cct_pkg::ERR_NONE);
      if (data_byte <= cct_pkg::SEP_MAX) begin
         s_mode = cct_pkg::MODE_IDLE;
      end else if (data_byte == cct_pkg::QUOTE_SINGLE ||
                   data_byte == cct_pkg::QUOTE_DOUBLE) begin
         s_kind = data_byte;
         s_mode = cct_pkg::MODE_STR;
      end else if (op_hit) begin
         s_kind = data_byte;
         s_has  = 1'b1;
         s_res  = cct_pkg::mk_res(cct_pkg::EV_DONE, 8'd0, data_byte, cct_pkg::ERR_NONE);
      end else if (word_hit) begin
         s_kind = data_byte;
         s_mode = cct_pkg::MODE_WORD;
         s_has  = 1'b1;
         s_res  = cct_pkg::mk_res(cct_pkg::EV_BYTE, data_byte, data_byte,
                                  cct_pkg::ERR_NONE);
      end else begin
         s_kind = data_byte;
         s_mode = cct_pkg::MODE_HALT;
         s_has  = 1'b1;
         s_res  = cct_pkg::mk_res(cct_pkg::EV_ERROR, 8'd0, data_byte,
                                  cct_pkg::ERR_UNEXP);
      end
   end

   // Per-mode handling of one beat
   always_comb begin
      mode_in = mode_ff;
      kind_in = kind_ff;
      n       = 2'd0;
      r0      = cct_pkg::mk_res(cct_pkg::EV_BYTE, 8'd0, 8'd0, cct_pkg::ERR_NONE);
      r1      = r0;
      if (end_marker) begin
         r0 = cct_pkg::mk_res(cct_pkg::EV_END, 8'd0, 8'd0, cct_pkg::ERR_NONE);
         n  = 2'd1;
         if (mode_ff == cct_pkg::MODE_WORD) begin
            r0 = cct_pkg::mk_res(cct_pkg::EV_DONE, 8'd0, kind_ff, cct_pkg::ERR_NONE);
            r1 = cct_pkg::mk_res(cct_pkg::EV_END, 8'd0, 8'd0, cct_pkg::ERR_NONE);
            n  = 2'd2;
         end else if (mode_ff == cct_pkg::MODE_STR || mode_ff == cct_pkg::MODE_ESC) begin
            r0 = cct_pkg::mk_res(cct_pkg::EV_ERROR, 8'd0, kind_ff, cct_pkg::ERR_UNTERM);
            r1 = cct_pkg::mk_res(cct_pkg::EV_END, 8'd0, 8'd0, cct_pkg::ERR_NONE);
            n  = 2'd2;
         end
         mode_in = cct_pkg::MODE_IDLE;
         kind_in = 8'd0;
      end else begin
         case (mode_ff)
            cct_pkg::MODE_HALT: begin
               mode_in = cct_pkg::MODE_HALT;
            end
            cct_pkg::MODE_WORD: begin
               if (word_hit) begin
                  r0 = cct_pkg::mk_res(cct_pkg::EV_BYTE, data_byte, kind_ff,
                                       cct_pkg::ERR_NONE);
                  n  = 2'd1;
               end else begin
                  // Close the word, then treat the byte as from idle
                  r0      = cct_pkg::mk_res(cct_pkg::EV_DONE, 8'd0, kind_ff,
                                            cct_pkg::ERR_NONE);
                  r1      = s_res;
                  n       = s_has ? 2'd2 : 2'd1;
                  mode_in = s_mode;
                  kind_in = s_kind;
               end
            end
            cct_pkg::MODE_STR: begin
               if (data_byte == kind_ff) begin
                  r0      = cct_pkg::mk_res(cct_pkg::EV_DONE, 8'd0, kind_ff,
                                            cct_pkg::ERR_NONE);
                  n       = 2'd1;
                  mode_in = cct_pkg::MODE_IDLE;
               end else if (data_byte == cct_pkg::ESCAPE_BYTE) begin
                  mode_in = cct_pkg::MODE_ESC;
               end else if (data_byte == cct_pkg::ZERO_BYTE) begin
                  r0      = cct_pkg::mk_res(cct_pkg::EV_ERROR, 8'd0, kind_ff,
                                            cct_pkg::ERR_ZERO);
                  n       = 2'd1;
                  mode_in = cct_pkg::MODE_HALT;
               end else begin
                  r0 = cct_pkg::mk_res(cct_pkg::EV_BYTE, data_byte, kind_ff,
                                       cct_pkg::ERR_NONE);
                  n  = 2'd1;
               end
            end
            cct_pkg::MODE_ESC: begin
               if (data_byte == cct_pkg::ZERO_BYTE) begin
                  r0      = cct_pkg::mk_res(cct_pkg::EV_ERROR, 8'd0, kind_ff,
                                            cct_pkg::ERR_ZERO);
                  mode_in = cct_pkg::MODE_HALT;
               end else begin
                  r0      = cct_pkg::mk_res(cct_pkg::EV_BYTE, data_byte, kind_ff,
                                            cct_pkg::ERR_NONE);
                  mode_in = cct_pkg::MODE_STR;
               end
               n = 2'd1;
            end
            default: begin
               r0      = s_res;
               n       = s_has ? 2'd1 : 2'd0;
               mode_in = s_mode;
               kind_in = s_kind;
            end
         endcase
      end
      // Flag the final result of the beat
      if (n == 2'd1) begin
         r0.last_result = 1'b1;
      end
      if (n == 2'd2) begin
         r1.last_result = 1'b1;
      end
   end

   assign step.count = n;
   assign step.r0    = r0;
   assign step.r1    = r1;

   // Update lexer state when the beat is processed
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= cct_pkg::MODE_IDLE;
         kind_ff <= 8'd0;
      end else if (advance) begin
         mode_ff <= mode_in;
         kind_ff <= kind_in;
      end
   end

endmodule

// ----- src/cct_out.sv -----
module cct_out (
   input  logic              clock,
   input  logic              reset,
   input  logic              load,
   input  cct_pkg::step_type step,
   output logic              can_take,
   cct_rsp_if.source         rsp
);

   cct_pkg::res_type res0_ff, res0_in;
   cct_pkg::res_type res1_ff, res1_in;
   logic [1:0]       cnt_ff, cnt_in;
   logic             fire;

   assign fire     = rsp.valid & rsp.ready;
   // Room for a new beat once the held results are gone by this edge
   assign can_take = (cnt_ff == 2'd0) | ((cnt_ff == 2'd1) & rsp.ready);

   always_comb begin
      res0_in = res0_ff;
      res1_in = res1_ff;
      cnt_in  = cnt_ff;
      if (load) begin
         res0_in = step.r0;
         res1_in = step.r1;
         cnt_in  = step.count;
      end else if (fire) begin
         // Advance the second result to the head
         res0_in = res1_ff;
         cnt_in  = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      res0_ff <= res0_in;
      res1_ff <= res1_in;
   end

   assign rsp.valid       = (cnt_ff != 2'd0);
   assign rsp.event_res   = res0_ff.event_res;
   assign rsp.token_byte  = res0_ff.token_byte;
   assign rsp.token_kind  = res0_ff.token_kind;
   assign rsp.error_code  = res0_ff.error_code;
   assign rsp.last_result = res0_ff.last_result;

endmodule

// ----- src/char_class_tokenizer_core.sv -----
// Channel | Dir | Handshake           | Payload
// req     | in  | valid/ready         | data_byte[7:0], end_marker
// rsp     | out | valid/ready         | event_res, token_byte, token_kind, error_code,
//         |     |                     | last_result
// csr     | in  | APB psel/penable    | paddr[5:3] selects one of eight 64-bit class registers
//
// One byte per cycle while the rsp side keeps up: a beat is latched in the input register,
// lexed from there and its results land in a two-entry result register.
// A byte that yields two results (word closed by an operator or bad byte, end
// marker after an open token) holds the input until the result register has room.
// Synchronous reset clears lexer mode, token kind and valids, and loads the
// default class maps (no operators, digits, letters and underscore as words).
// A stalled rsp side holds the result register and then the input register.
module char_class_tokenizer_core (
   input  logic                           clock,
   input  logic                           reset,
   cct_req_if.sink                        req,
   cct_rsp_if.source                      rsp,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [cct_pkg::CFG_ADDR_W-1:0] csr_paddr,
   input  logic [cct_pkg::CFG_DATA_W-1:0] csr_pwdata,
   output logic [cct_pkg::CFG_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   cct_pkg::class_maps_type maps;
   cct_pkg::step_type       step;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_end_ff;
   logic       can_take;
   logic       advance;
   logic       accept;

   assign advance   = in_valid_ff & can_take;
   assign req.ready = ~in_valid_ff | advance;
   assign accept    = req.valid & req.ready;

   // Input register: capture a beat, drop it once lexed
   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req.data_byte;
         in_end_ff  <= req.end_marker;
      end
   end

   cct_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .maps        (maps)
   );

   cct_lexer u_lexer (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .data_byte  (in_byte_ff),
      .end_marker (in_end_ff),
      .maps       (maps),
      .step       (step)
   );

   cct_out u_out (
      .clock    (clock),
      .reset    (reset),
      .load     (advance),
      .step     (step),
      .can_take (can_take),
      .rsp      (rsp)
   );

endmodule
